FILE: rtl/sha1s_pkg.sv
// sha1s_pkg: shared types, constants and codes for the streaming sha-1 block
// used by sha1s_ctrl, sha1s_datapath and sha1_stream_hash
// no dependencies
package sha1s_pkg;

	localparam logic [31:0] K0 = 32'h5A82_7999;
	localparam logic [31:0] K1 = 32'h6ED9_EBA1;
	localparam logic [31:0] K2 = 32'h8F1B_BCDC;
	localparam logic [31:0] K3 = 32'hCA62_C1D6;

	localparam logic [31:0] IV0 = 32'h6745_2301;
	localparam logic [31:0] IV1 = 32'hEFCD_AB89;
	localparam logic [31:0] IV2 = 32'h98BA_DCFE;
	localparam logic [31:0] IV3 = 32'h1032_5476;
	localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

	localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
	localparam int          NUM_ROUNDS = 80;
	localparam int          NUM_WORDS  = 16;
	localparam int          PAD_WORDS  = 14;
	localparam int          DIG_WORDS  = 5;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last_word;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_result;
	} dig_item_t;

	// what gets pushed into the block buffer
	typedef enum logic [2:0] {
		SRC_INPUT,
		SRC_PAD80,
		SRC_ZERO,
		SRC_LENHI,
		SRC_LENLO
	} push_src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_FIN,
		ST_PAD80,
		ST_PADZ,
		ST_LENHI,
		ST_LENLO,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic        push;
		push_src_t   src;
		logic        round_en;
		logic        fin;
		logic        clear;
		logic [2:0]  out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic will_fill;
		logic at56;
		logic last_round;
	} dp_stat_t;

endpackage

FILE: rtl/sha1_stream_hash.sv
// sha1_stream_hash: a message word is taken while idle; the sixteenth word of a
// block starts 80 rounds on the single round unit and one chaining add, during
// which no word is taken; last word: padding, length and final block follow,
// then five digest words at one per cycle while dig_stall is low; no input is
// taken until the fifth is taken
// asynchronous reset loads the initial vector and empties the block buffer
module sha1_stream_hash import sha1s_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_stall,
	input  msg_item_t msg,
	output logic      dig_valid,
	input  logic      dig_stall,
	output dig_item_t dig
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [2:0]  word_index;
	logic [31:0] digest_word;

	sha1s_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.last_word  (msg.last_word),
		.msg_stall  (msg_stall),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.word_index (word_index),
		.stat       (stat),
		.cmd        (cmd)
	);

	sha1s_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg         (msg),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (digest_word)
	);

	assign dig.digest_word = digest_word;
	assign dig.word_index  = word_index;
	assign dig.last_result = (word_index == 3'(DIG_WORDS - 1));

endmodule

FILE: rtl/sha1s_datapath.sv
// sha1s_datapath: byte packing, 16-word schedule line, one-round-per-cycle
// compression and chaining words; driven by sha1s_ctrl
// depends on sha1s_pkg
module sha1s_datapath import sha1s_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  msg_item_t   msg,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [31:0] digest_word
);

	logic [31:0] hash_q [DIG_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [NUM_WORDS];
	logic [6:0]  rcnt_q;
	logic [4:0]  wcnt_q;
	logic [1:0]  pcnt_q;
	logic [23:0] pend_q;
	logic [63:0] bits_q;

	logic [31:0] src_word, src_mask, src_m;
	logic [2:0]  src_n, tot;
	logic [55:0] comb;
	logic        emit;
	logic [31:0] f, k, t, sched, w_new;

	always_comb begin
		unique case (cmd.src)
			SRC_INPUT: begin
				src_word = msg.data_word;
				src_n    = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
			end
			SRC_PAD80: begin
				src_word = PAD_WORD;
				src_n    = 3'd1;
			end
			SRC_ZERO: begin
				src_word = '0;
				src_n    = 3'd4 - {1'b0, pcnt_q};
			end
			SRC_LENHI: begin
				src_word = bits_q[63:32];
				src_n    = 3'd4;
			end
			SRC_LENLO: begin
				src_word = bits_q[31:0];
				src_n    = 3'd4;
			end
			default: begin
				src_word = '0;
				src_n    = 3'd0;
			end
		endcase
		unique case (src_n)
			3'd0:    src_mask = 32'h0000_0000;
			3'd1:    src_mask = 32'hFF00_0000;
			3'd2:    src_mask = 32'hFFFF_0000;
			3'd3:    src_mask = 32'hFFFF_FF00;
			default: src_mask = 32'hFFFF_FFFF;
		endcase
		src_m = src_word & src_mask;
		// pending bytes stay on top, new bytes follow them
		comb  = {pend_q, 32'h0} | ({src_m, 24'h0} >> {pcnt_q, 3'b000});
		tot   = {1'b0, pcnt_q} + src_n;
		emit  = tot[2];
	end

	assign stat.will_fill  = emit && (wcnt_q == 5'(NUM_WORDS - 1));
	assign stat.at56       = (wcnt_q == 5'(PAD_WORDS)) && (pcnt_q == 2'd0);
	assign stat.last_round = (rcnt_q == 7'(NUM_ROUNDS - 1));

	always_comb begin
		priority if (rcnt_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rcnt_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rcnt_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t     = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {sched[30:0], sched[31]};
	end

	always_comb begin
		unique case (cmd.out_idx)
			3'd0:    digest_word = hash_q[0];
			3'd1:    digest_word = hash_q[1];
			3'd2:    digest_word = hash_q[2];
			3'd3:    digest_word = hash_q[3];
			default: digest_word = hash_q[4];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '{IV0, IV1, IV2, IV3, IV4};
			rcnt_q <= '0;
			wcnt_q <= '0;
			pcnt_q <= '0;
			pend_q <= '0;
			bits_q <= '0;
		end else begin
			rcnt_q <= cmd.round_en ? rcnt_q + 7'd1 : 7'd0;
			if (cmd.clear) begin
				hash_q <= '{IV0, IV1, IV2, IV3, IV4};
				wcnt_q <= '0;
				pcnt_q <= '0;
				pend_q <= '0;
				bits_q <= '0;
			end else begin
				if (cmd.push) begin
					pcnt_q <= tot[1:0];
					pend_q <= emit ? comb[23:0] : comb[55:32];
					if (emit)
						wcnt_q <= wcnt_q + 5'd1;
					if (cmd.src == SRC_INPUT)
						bits_q <= bits_q + {58'h0, src_n, 3'b000};
				end
				if (cmd.fin) begin
					hash_q[0] <= hash_q[0] + a_q;
					hash_q[1] <= hash_q[1] + b_q;
					hash_q[2] <= hash_q[2] + c_q;
					hash_q[3] <= hash_q[3] + d_q;
					hash_q[4] <= hash_q[4] + e_q;
					wcnt_q    <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < NUM_WORDS - 1; i++)
				w_q[i] <= w_q[i + 1];
			w_q[NUM_WORDS - 1] <= w_new;
		end else begin
			a_q <= hash_q[0];
			b_q <= hash_q[1];
			c_q <= hash_q[2];
			d_q <= hash_q[3];
			e_q <= hash_q[4];
			if (cmd.push && emit) begin
				for (int i = 0; i < NUM_WORDS - 1; i++)
					w_q[i] <= w_q[i + 1];
				w_q[NUM_WORDS - 1] <= comb[55:24];
			end
		end
	end

endmodule

FILE: rtl/sha1s_ctrl.sv
// sha1s_ctrl: sequencer for message intake, padding, compression and
// digest output; commands sha1s_datapath
// depends on sha1s_pkg
module sha1s_ctrl import sha1s_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       msg_valid,
	input  logic       last_word,
	output logic       msg_stall,
	output logic       dig_valid,
	input  logic       dig_stall,
	output logic [2:0] word_index,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	ctrl_state_t ret_q, ret_d;
	logic [2:0]  idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			idx_q   <= idx_d;
		end
	end

	assign msg_stall  = (state_q != ST_IDLE);
	assign dig_valid  = (state_q == ST_OUT);
	assign word_index = idx_q;

	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		idx_d        = idx_q;
		cmd.push     = 1'b0;
		cmd.src      = SRC_INPUT;
		cmd.round_en = 1'b0;
		cmd.fin      = 1'b0;
		cmd.clear    = 1'b0;
		cmd.out_idx  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.src = SRC_INPUT;
				if (msg_valid) begin
					cmd.push = 1'b1;
					if (stat.will_fill) begin
						state_d = ST_COMP;
						ret_d   = last_word ? ST_PAD80 : ST_IDLE;
					end else if (last_word) begin
						state_d = ST_PAD80;
					end
				end
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
				if (stat.last_round)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ret_q;
			end
			ST_PAD80: begin
				cmd.src  = SRC_PAD80;
				cmd.push = 1'b1;
				state_d  = ST_PADZ;
				if (stat.will_fill) begin
					state_d = ST_COMP;
					ret_d   = ST_PADZ;
				end
			end
			ST_PADZ: begin
				cmd.src = SRC_ZERO;
				if (stat.at56) begin
					state_d = ST_LENHI;
				end else begin
					cmd.push = 1'b1;
					if (stat.will_fill) begin
						state_d = ST_COMP;
						ret_d   = ST_PADZ;
					end
				end
			end
			ST_LENHI: begin
				cmd.src  = SRC_LENHI;
				cmd.push = 1'b1;
				state_d  = ST_LENLO;
			end
			ST_LENLO: begin
				// always completes the block
				cmd.src  = SRC_LENLO;
				cmd.push = 1'b1;
				state_d  = ST_COMP;
				ret_d    = ST_OUT;
				idx_d    = '0;
			end
			ST_OUT: begin
				if (!dig_stall) begin
					if (idx_q == 3'(DIG_WORDS - 1)) begin
						cmd.clear = 1'b1;
						idx_d     = '0;
						state_d   = ST_IDLE;
						ret_d     = ST_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: tb/testbench.sv
// testbench for sha1_stream_hash: drives messages word by word and checks every digest word
// holds its own sha-1 model in a small scoreboard class; depends on sha1s_pkg and the rtl
module testbench;
	import sha1s_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class digest_scoreboard;
		logic [31:0] chain[5];
		logic [7:0]  blk[64];
		int          fill;
		logic [63:0] bit_len;
		dig_item_t   expected_digests[$];
		int          fails;

		function new();
			fails = 0;
			restart();
		endfunction

		function void restart();
			chain[0] = IV0;
			chain[1] = IV1;
			chain[2] = IV2;
			chain[3] = IV3;
			chain[4] = IV4;
			foreach (blk[i]) blk[i] = 8'h00;
			fill = 0;
			bit_len = '0;
		endfunction

		function void run_rounds();
			logic [31:0] w[16];
			logic [31:0] a, b, c, d, e, f, k, t, x;
			int r;
			for (r = 0; r < 16; r++)
				w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (r = 0; r < 80; r++) begin
				if (r >= 16) begin
					// message schedule kept in a 16-word circular window
					x = w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16];
					w[r%16] = {x[30:0], x[31]};
				end
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = K0;
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = K1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K2;
				end else begin
					f = b ^ c ^ d;
					k = K3;
				end
				t = {a[26:0], a[31:27]} + f + e + k + w[r%16];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void absorb_byte(logic [7:0] v);
			blk[fill] = v;
			fill = (fill + 1) % 64;
			if (fill == 0)
				run_rounds();
		endfunction

		function void note_request(msg_item_t m);
			int n;
			int i;
			logic [63:0] len;
			dig_item_t exp_item;
			// counts above four carry a full word
			n = (m.byte_count > 3'd4) ? 4 : int'(m.byte_count);
			for (i = 0; i < n; i++) begin
				absorb_byte(m.data_word[31-8*i -: 8]);
				bit_len += 64'd8;
			end
			if (m.last_word) begin
				len = bit_len;
				absorb_byte(8'h80);
				while (fill != 56)
					absorb_byte(8'h00);
				for (i = 0; i < 8; i++)
					absorb_byte(len[63-8*i -: 8]);
				for (i = 0; i < DIG_WORDS; i++) begin
					exp_item.digest_word = chain[i];
					exp_item.word_index  = 3'(i);
					exp_item.last_result = (i == DIG_WORDS - 1);
					expected_digests.push_back(exp_item);
				end
				restart();
			end
		endfunction

		function void check_digest(dig_item_t got);
			dig_item_t exp_item;
			if (expected_digests.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected digest word: got %h idx %0d last %0b",
						got.digest_word, got.word_index, got.last_result);
			end else begin
				exp_item = expected_digests.pop_front();
				if (exp_item.digest_word !== got.digest_word ||
						exp_item.word_index !== got.word_index ||
						exp_item.last_result !== got.last_result) begin
					fails++;
					if (fails <= 10)
						$display({"digest mismatch: expected %h idx %0d last %0b, ",
							"got %h idx %0d last %0b"},
							exp_item.digest_word, exp_item.word_index, exp_item.last_result,
							got.digest_word, got.word_index, got.last_result);
				end
			end
		endfunction

		function int pending();
			return expected_digests.size();
		endfunction
	endclass

	typedef struct {
		msg_item_t item;
		bit        calm;
		bit        drain;
	} msg_entry_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      msg_valid;
	logic      msg_stall;
	msg_item_t msg;
	logic      dig_valid;
	logic      dig_stall;
	dig_item_t dig;

	digest_scoreboard sb = new();
	msg_entry_t       msg_q[$];
	bit               calm = 1'b0;

	sha1_stream_hash dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back to back, now and then a long pause
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_word(logic [31:0] d, logic [2:0] n, bit last, bit quiet, bit drain);
		msg_entry_t e;
		e.item.data_word  = d;
		e.item.byte_count = n;
		e.item.last_word  = last;
		e.calm  = quiet;
		e.drain = drain;
		msg_q.push_back(e);
	endtask

	task automatic build_directed();
		int j;
		// empty message
		add_word(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0, 1'b0);
		// three-byte message, sent only once the empty digest is fully out
		add_word(32'h6162_6300, 3'd3, 1'b1, 1'b0, 1'b1);
		// empty word not last, oversized counts, extremes of the data
		add_word(32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b0);
		add_word(32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 1'b0);
		add_word(32'h0000_0000, 3'd4, 1'b0, 1'b0, 1'b0);
		add_word(32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, 1'b0);
		add_word(32'h1234_5678, 3'd5, 1'b0, 1'b0, 1'b0);
		add_word(32'hA5A5_A5A5, 3'd6, 1'b1, 1'b0, 1'b0);
		add_word(32'h0000_0000, 3'd4, 1'b1, 1'b1, 1'b0);
		// 56 bytes: the padding spills into a second block
		for (j = 0; j < 14; j++)
			add_word($urandom, 3'd4, j == 13, 1'b0, 1'b0);
	endtask

	task automatic build_random();
		int counted, nwords, r, j;
		bit quiet, drain, last;
		logic [31:0] d;
		logic [2:0] n;
		counted = 0;
		while (counted < 85) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				nwords = $urandom_range(1, 12);
			else if (r < 96)
				nwords = $urandom_range(13, 36);
			else
				nwords = $urandom_range(37, 50);
			quiet = ($urandom_range(0, 3) == 0);
			drain = ($urandom_range(0, 5) == 0);
			for (j = 0; j < nwords; j++) begin
				last = (j == nwords - 1);
				r = $urandom_range(0, 99);
				if (r < 10)
					d = 32'h0000_0000;
				else if (r < 20)
					d = 32'hFFFF_FFFF;
				else
					d = $urandom;
				r = $urandom_range(0, 99);
				if (last)
					n = 3'($urandom_range(0, 7));
				else if (r < 70)
					n = 3'd4;
				else if (r < 85)
					n = 3'($urandom_range(1, 3));
				else if (r < 92)
					n = 3'($urandom_range(5, 7));
				else
					n = 3'd0;
				add_word(d, n, last, quiet, drain && j == 0);
				counted++;
			end
		end
	endtask

	task automatic run_sender();
		int gap;
		foreach (msg_q[i]) begin
			calm = msg_q[i].calm;
			if (msg_q[i].drain) begin
				msg_valid = 1'b0;
				while (sb.pending() != 0)
					@(negedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				msg_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			msg = msg_q[i].item;
			msg_valid = 1'b1;
			forever begin
				@(posedge clk);
				if (msg_stall === 1'b0)
					break;
			end
			sb.note_request(msg_q[i].item);
			@(negedge clk);
		end
		msg_valid = 1'b0;
	endtask

	task automatic run_receiver();
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				dig_stall = 1'b1;
				hold--;
			end else begin
				dig_stall = 1'b0;
				hold = pick_gap();
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && dig_valid && !dig_stall)
			sb.check_digest(dig);
	end

	initial begin
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		dig_stall = 1'b0;
		build_directed();
		build_random();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		fork
			run_receiver();
		join_none
		run_sender();
		while (sb.pending() != 0)
			@(posedge clk);
		// a stray extra word would show up within the final block's latency
		repeat (250) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/sha1s_pkg.sv
rtl/sha1s_datapath.sv
rtl/sha1s_ctrl.sv
rtl/sha1_stream_hash.sv
tb/testbench.sv
